### rtl/cmtr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collapse map triangle remap: shared definitions
// Widths, codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package cmtr_pkg;

	localparam int IDX_W            = 12;
	localparam int CNT_W            = 13;
	localparam int MAX_VERTICES_DEF = 4096;

	localparam logic [CNT_W-1:0] KEPT_RESET = 13'd4096;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_REMAP = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FETCH,
		ST_FINISH
	} cmtr_state_t;

	typedef struct packed {
		logic capture;
		logic load_write;
		logic read_req;
		logic hop_zero;
		logic hop_load;
		logic corner_done;
		logic set_error;
		logic emit;
	} cmtr_cmd_t;

	typedef struct packed {
		logic above_kept;
		logic hop_limit;
		logic in_table;
		logic last_corner;
	} cmtr_status_t;

endpackage

### rtl/cmtr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cmtr_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/cmtr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collapse map triangle remap: controller
// Sequences the corner walks, one hop or one corner decision per step.
// ----------------------------------------------------------------------------
module cmtr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  op,
	input  cmtr_pkg::cmtr_status_t status,
	output cmtr_pkg::cmtr_cmd_t    cmd,
	output logic                  busy
);

	cmtr_pkg::cmtr_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmtr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cmtr_pkg::ST_IDLE: begin
				if (start && op == cmtr_pkg::OP_REMAP) begin
					state_d = cmtr_pkg::ST_CHECK;
				end
			end
			cmtr_pkg::ST_CHECK: begin
				if (!status.above_kept) begin
					if (status.last_corner) begin
						state_d = cmtr_pkg::ST_FINISH;
					end
				end else if (status.hop_limit) begin
					state_d = cmtr_pkg::ST_FINISH;
				end else if (status.in_table) begin
					state_d = cmtr_pkg::ST_FETCH;
				end
			end
			cmtr_pkg::ST_FETCH: begin
				state_d = cmtr_pkg::ST_CHECK;
			end
			cmtr_pkg::ST_FINISH: begin
				state_d = cmtr_pkg::ST_IDLE;
			end
			default: begin
				state_d = cmtr_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			cmtr_pkg::ST_IDLE: begin
				cmd.capture    = start && op == cmtr_pkg::OP_REMAP;
				cmd.load_write = start && op == cmtr_pkg::OP_LOAD;
			end
			cmtr_pkg::ST_CHECK: begin
				if (!status.above_kept) begin
					cmd.corner_done = 1'b1;
				end else if (status.hop_limit) begin
					cmd.set_error = 1'b1;
				end else if (status.in_table) begin
					cmd.read_req = 1'b1;
				end else begin
					cmd.hop_zero = 1'b1;
				end
			end
			cmtr_pkg::ST_FETCH: begin
				cmd.hop_load = 1'b1;
			end
			cmtr_pkg::ST_FINISH: begin
				cmd.emit = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign busy = state_q != cmtr_pkg::ST_IDLE;

endmodule

### rtl/cmtr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collapse map triangle remap: datapath
// Collapse map memory, walk registers, hop counter and result registers.
// ----------------------------------------------------------------------------
module cmtr_datapath #(
	parameter int MAX_VERTICES = cmtr_pkg::MAX_VERTICES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cmtr_pkg::cmtr_cmd_t          cmd,
	output cmtr_pkg::cmtr_status_t       status,
	input  logic                        cfg_we,
	input  logic [cmtr_pkg::CNT_W-1:0]  cfg_wdata,
	input  logic [cmtr_pkg::IDX_W-1:0]  entry_index,
	input  logic [cmtr_pkg::IDX_W-1:0]  entry_parent,
	input  logic [cmtr_pkg::IDX_W-1:0]  corner_a,
	input  logic [cmtr_pkg::IDX_W-1:0]  corner_b,
	input  logic [cmtr_pkg::IDX_W-1:0]  corner_c,
	output logic                        result_valid,
	output logic [cmtr_pkg::IDX_W-1:0]  mapped_a,
	output logic [cmtr_pkg::IDX_W-1:0]  mapped_b,
	output logic [cmtr_pkg::IDX_W-1:0]  mapped_c,
	output logic                        walk_error
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int HW = $clog2(MAX_VERTICES + 1);

	logic [cmtr_pkg::CNT_W-1:0] kept_q;
	logic [cmtr_pkg::IDX_W-1:0] v_q, cb_q, cc_q, ma_q, mb_q, mc_q;
	logic [HW-1:0]              hops_q;
	logic [1:0]                 sel_q;
	logic                       err_q;
	logic                       valid_q;
	logic [cmtr_pkg::IDX_W-1:0] out_a_q, out_b_q, out_c_q;
	logic                       out_err_q;

	logic [31:0]                widx, wv;
	logic [AW-1:0]              waddr, raddr;
	logic                       wr_en;
	logic [cmtr_pkg::IDX_W-1:0] rdata;
	logic [cmtr_pkg::IDX_W-1:0] corner_val;
	logic                       distinct;

	assign widx  = 32'(entry_index);
	assign wv    = 32'(v_q);
	assign waddr = widx[AW-1:0];
	assign raddr = wv[AW-1:0];
	assign wr_en = cmd.load_write && (widx < 32'(MAX_VERTICES));

	cmtr_ram #(
		.WIDTH(cmtr_pkg::IDX_W),
		.DEPTH(MAX_VERTICES)
	) u_map (
		.clk   (clk),
		.we    (wr_en),
		.waddr (waddr),
		.wdata (entry_parent),
		.re    (cmd.read_req),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign status.above_kept  = (kept_q != '0) && ({1'b0, v_q} >= kept_q);
	assign status.hop_limit   = 32'(hops_q) >= 32'(MAX_VERTICES);
	assign status.in_table    = wv < 32'(MAX_VERTICES);
	assign status.last_corner = sel_q == 2'd2;

	assign corner_val = (kept_q == '0) ? '0 : v_q;
	assign distinct   = (ma_q != mb_q) && (mb_q != mc_q) && (ma_q != mc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q  <= cmtr_pkg::KEPT_RESET;
			valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				kept_q <= cfg_wdata;
			end
			valid_q <= cmd.emit && (err_q || distinct);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			v_q    <= corner_a;
			cb_q   <= corner_b;
			cc_q   <= corner_c;
			sel_q  <= 2'd0;
			hops_q <= '0;
			err_q  <= 1'b0;
		end
		if (cmd.hop_zero) begin
			v_q    <= '0;
			hops_q <= hops_q + 1'b1;
		end
		if (cmd.hop_load) begin
			v_q    <= rdata;
			hops_q <= hops_q + 1'b1;
		end
		if (cmd.set_error) begin
			err_q <= 1'b1;
		end
		if (cmd.corner_done) begin
			hops_q <= '0;
			sel_q  <= sel_q + 2'd1;
			case (sel_q)
				2'd0: begin
					ma_q <= corner_val;
					v_q  <= cb_q;
				end
				2'd1: begin
					mb_q <= corner_val;
					v_q  <= cc_q;
				end
				default: begin
					mc_q <= corner_val;
				end
			endcase
		end
		if (cmd.emit) begin
			out_a_q   <= err_q ? '0 : ma_q;
			out_b_q   <= err_q ? '0 : mb_q;
			out_c_q   <= err_q ? '0 : mc_q;
			out_err_q <= err_q;
		end
	end

	assign result_valid = valid_q;
	assign mapped_a     = out_a_q;
	assign mapped_b     = out_b_q;
	assign mapped_c     = out_c_q;
	assign walk_error   = out_err_q;

endmodule

### rtl/collapse_map_triangle_remap_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collapse map triangle remap: top level
// Looks up triangle corners through a progressive mesh collapse map.
//
// Items enter on start while busy is low. A load item (op = 0) writes one
// collapse map entry in its transfer cycle; busy stays low, so loads run one
// per cycle and give no result. A remap item (op = 1) walks each corner's
// chain in turn until it drops below kept_vertex_count. A hop from a vertex
// inside the map is one read through the registered memory port; a vertex
// beyond the map hops to 0 without a read. busy rises after the transfer
// and drops as the result strobe appears.
// A chain still open after MAX_VERTICES hops ends the walk at once with
// walk_error set and all corners 0.
// The result appears for one cycle with result_valid; degenerate triangles
// give no strobe unless walk_error is set. The receiver cannot stall the
// block. kept_vertex_count is written through cfg_we/cfg_wdata; the user
// must write it only while idle; the block does not enforce it. Reset sets
// kept_vertex_count to 4096; map contents are undefined until loaded.
// ----------------------------------------------------------------------------
module collapse_map_triangle_remap_top #(
	parameter int MAX_VERTICES = cmtr_pkg::MAX_VERTICES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        op,
	input  logic [cmtr_pkg::IDX_W-1:0]  entry_index,
	input  logic [cmtr_pkg::IDX_W-1:0]  entry_parent,
	input  logic [cmtr_pkg::IDX_W-1:0]  corner_a,
	input  logic [cmtr_pkg::IDX_W-1:0]  corner_b,
	input  logic [cmtr_pkg::IDX_W-1:0]  corner_c,
	input  logic                        cfg_we,
	input  logic [cmtr_pkg::CNT_W-1:0]  cfg_wdata,
	output logic                        result_valid,
	output logic [cmtr_pkg::IDX_W-1:0]  mapped_a,
	output logic [cmtr_pkg::IDX_W-1:0]  mapped_b,
	output logic [cmtr_pkg::IDX_W-1:0]  mapped_c,
	output logic                        walk_error
);

	cmtr_pkg::cmtr_cmd_t    cmd;
	cmtr_pkg::cmtr_status_t status;
	logic                   ctrl_busy;

	cmtr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.status (status),
		.cmd    (cmd),
		.busy   (ctrl_busy)
	);

	cmtr_datapath #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.entry_index  (entry_index),
		.entry_parent (entry_parent),
		.corner_a     (corner_a),
		.corner_b     (corner_b),
		.corner_c     (corner_c),
		.result_valid (result_valid),
		.mapped_a     (mapped_a),
		.mapped_b     (mapped_b),
		.mapped_c     (mapped_c),
		.walk_error   (walk_error)
	);

	assign busy = ctrl_busy;

endmodule
